[design/ftd_pkg.sv]
// Package for the fixed-point to decimal text block.
// Holds widths, character codes, register indexes, FSM state and the
// command/status structs shared by controller and datapath. No dependencies.
package ftd_pkg;

	localparam int INT_W        = 32;
	localparam int FRAC_W       = 64;
	localparam int CHAR_W       = 8;
	localparam int CFG_W        = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int INT_DIGITS   = 10;
	localparam int DIG_IDX_W    = 4;
	localparam int STEP_W       = 5;
	localparam int COUNT_W      = 5;

	localparam logic [CFG_W-1:0] MAX_FRACTION_DIGITS = 5'd20;
	localparam logic [CFG_W-1:0] FRACTION_DIGITS_RST = 5'd6;
	localparam logic [CFG_W-1:0] CAPACITY_RST        = 5'd31;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRACTION_DIGITS = 1'd0,
		REG_CAPACITY        = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_PREP,
		S_INT,
		S_POINT,
		S_FRAC,
		S_END
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic int_start;
		logic emit_int;
		logic emit_point;
		logic emit_frac;
		logic emit_end;
	} ftd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic conv_last;
		logic int_last;
		logic room_ok;
		logic frac_left;
		logic can_emit;
	} ftd_sts_t;

endpackage

[design/ftd_ifs.sv]
// Handshake channel interfaces: input word (32.64 fixed point) and output word
// (one character). Depends on ftd_pkg.
interface ftd_in_if;
	import ftd_pkg::*;
	logic              valid;
	logic              ready;
	logic [INT_W-1:0]  int_part;
	logic [INT_W-1:0]  frac_high;
	logic [INT_W-1:0]  frac_low;

	modport source(output valid, output int_part, output frac_high, output frac_low,
		input ready);
	modport sink(input valid, input int_part, input frac_high, input frac_low,
		output ready);
endinterface

interface ftd_out_if;
	import ftd_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last;

	modport source(output valid, output out_char, output last, input ready);
	modport sink(input valid, input out_char, input last, output ready);
endinterface

[design/fixed_point_to_decimal_text.sv]
// Top level of the fixed-point to decimal text block.
// Instantiates ftd_ctrl and ftd_dp; depends on ftd_pkg and ftd_ifs.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------
//   din      | in  | valid/ready   | int_part, frac_high, frac_low
//   dout     | out | valid/ready   | out_char, last
//   cfg      | in  | cfg_we        | cfg_index, cfg_wdata
//
// One word at a time: a load, the shift-add-3 conversion of the integer
// part, a step to find the leading digit, one character per cycle while dout
// is not stalled (up to 32 including the terminator) and a step to leave the
// text states before the terminator.
// din.ready is high only while idle; the output register lets the final
// terminator wait for dout.ready while the next word is taken.
// A stall on dout holds the sequencer in its emitting states. Reset clears control state only.
module fixed_point_to_decimal_text (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ftd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ftd_pkg::CFG_W-1:0]     cfg_wdata,
	ftd_in_if.sink                        din,
	ftd_out_if.source                     dout
);
	import ftd_pkg::*;

	ftd_cmd_t cmd;
	ftd_sts_t sts;

	ftd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ftd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.int_part  (din.int_part),
		.frac_high (din.frac_high),
		.frac_low  (din.frac_low),
		.cmd       (cmd),
		.sts       (sts),
		.dout      (dout)
	);

endmodule

[design/ftd_ctrl.sv]
// Controller FSM: sequences load, integer conversion, character emission.
// Depends on ftd_pkg.
module ftd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ftd_pkg::ftd_sts_t sts,
	output ftd_pkg::ftd_cmd_t cmd
);
	import ftd_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CONV;
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_last) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.int_start = 1'b1;
				state_d       = S_INT;
			end
			S_INT: begin
				if (!sts.room_ok) begin
					state_d = S_END;
				end else if (sts.can_emit) begin
					cmd.emit_int = 1'b1;
					if (sts.int_last) begin
						state_d = S_POINT;
					end
				end
			end
			S_POINT: begin
				if (!sts.frac_left || !sts.room_ok) begin
					state_d = S_END;
				end else if (sts.can_emit) begin
					cmd.emit_point = 1'b1;
					state_d        = S_FRAC;
				end
			end
			S_FRAC: begin
				if (!sts.frac_left || !sts.room_ok) begin
					state_d = S_END;
				end else if (sts.can_emit) begin
					cmd.emit_frac = 1'b1;
				end
			end
			S_END: begin
				if (sts.can_emit) begin
					cmd.emit_end = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[design/ftd_dp.sv]
// Datapath: config registers, shift-add-3 integer conversion, times-ten
// fraction digits, character counters and the output register.
// Depends on ftd_pkg and ftd_ifs.
module ftd_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ftd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ftd_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic [ftd_pkg::INT_W-1:0]    int_part,
	input  logic [ftd_pkg::INT_W-1:0]    frac_high,
	input  logic [ftd_pkg::INT_W-1:0]    frac_low,
	input  ftd_pkg::ftd_cmd_t            cmd,
	output ftd_pkg::ftd_sts_t            sts,
	ftd_out_if.source                    dout
);
	import ftd_pkg::*;

	logic [CFG_W-1:0]     fraction_digits_q;
	logic [CFG_W-1:0]     capacity_q;
	logic [INT_W-1:0]     bin_q;
	logic [3:0]           bcd_q [INT_DIGITS];
	logic [3:0]           bcd_d [INT_DIGITS];
	logic [FRAC_W-1:0]    frac_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIG_IDX_W-1:0] idx_q;
	logic [DIG_IDX_W-1:0] top_idx;
	logic [COUNT_W-1:0]   k_q;
	logic [CFG_W-1:0]     fd_left_q;
	logic [CFG_W-1:0]     fd_sat;
	logic [FRAC_W+3:0]    frac_x10;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;
	logic                 emit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fraction_digits_q <= FRACTION_DIGITS_RST;
			capacity_q        <= CAPACITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRACTION_DIGITS: fraction_digits_q <= cfg_wdata;
				REG_CAPACITY:        capacity_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign fd_sat = (fraction_digits_q > MAX_FRACTION_DIGITS) ?
		MAX_FRACTION_DIGITS : fraction_digits_q;

	// One shift-add-3 step: adjust each digit, then shift in the next bit
	always_comb begin
		logic [3:0] adj [INT_DIGITS];
		for (int i = 0; i < INT_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		bcd_d[0] = {adj[0][2:0], bin_q[INT_W-1]};
		for (int i = 1; i < INT_DIGITS; i++) begin
			bcd_d[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	// Highest nonzero digit, digit zero when the value is zero
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < INT_DIGITS; i++) begin
			if (bcd_q[i] != 4'd0) begin
				top_idx = DIG_IDX_W'(i);
			end
		end
	end

	// Fraction times ten: top four bits are the digit, the rest carries on
	assign frac_x10 = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);

	// Conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= int_part;
			frac_q <= {frac_high, frac_low};
			for (int i = 0; i < INT_DIGITS; i++) begin
				bcd_q[i] <= 4'd0;
			end
		end else if (cmd.conv_step) begin
			bin_q <= bin_q << 1;
			bcd_q <= bcd_d;
		end else if (cmd.emit_frac) begin
			frac_q <= frac_x10[FRAC_W-1:0];
		end
	end

	// Step, digit and character counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			idx_q     <= '0;
			k_q       <= '0;
			fd_left_q <= '0;
		end else begin
			if (cmd.load) begin
				step_q    <= '0;
				k_q       <= '0;
				fd_left_q <= fd_sat;
			end else begin
				if (cmd.conv_step) begin
					step_q <= step_q + 1'b1;
				end
				if (cmd.emit_int || cmd.emit_point || cmd.emit_frac) begin
					k_q <= k_q + 1'b1;
				end
				if (cmd.emit_frac) begin
					fd_left_q <= fd_left_q - 1'b1;
				end
			end
			if (cmd.int_start) begin
				idx_q <= top_idx;
			end else if (cmd.emit_int) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	// Output register
	assign emit = cmd.emit_int || cmd.emit_point || cmd.emit_frac || cmd.emit_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_last_q <= cmd.emit_end;
			if (cmd.emit_int) begin
				out_char_q <= CHAR_ZERO + {4'd0, bcd_q[idx_q]};
			end else if (cmd.emit_point) begin
				out_char_q <= CHAR_POINT;
			end else if (cmd.emit_frac) begin
				out_char_q <= CHAR_ZERO + {4'd0, frac_x10[FRAC_W+3:FRAC_W]};
			end else begin
				out_char_q <= CHAR_NUL;
			end
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.out_char = out_char_q;
	assign dout.last     = out_last_q;

	// Status to controller
	assign sts.conv_last = &step_q;
	assign sts.int_last  = (idx_q == '0);
	assign sts.room_ok   = (k_q < capacity_q);
	assign sts.frac_left = (fd_left_q != '0);
	assign sts.can_emit  = !out_valid_q || dout.ready;

endmodule

[design/ftd_checker.sv]
// Port-level checker for fixed_point_to_decimal_text, attached by bind.
// Depends on ftd_pkg.
module ftd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ftd_pkg::CHAR_W-1:0] out_char,
	input logic                       out_last
);
	import ftd_pkg::*;

	// Hold a stalled output word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output word changed while stalled");

	// Drop ready once a word is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken during conversion");

	// Terminator is a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_char == CHAR_NUL)
		else $error("terminator not zero");

	// Text characters are digits or the point
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_char == CHAR_POINT ||
			(out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 8'd9))
		else $error("bad text character");

endmodule

bind fixed_point_to_decimal_text ftd_checker u_ftd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_char  (dout.out_char),
	.out_last  (dout.last)
);
